// ----- design/mbds_pkg.sv -----
`default_nettype none
package mbds_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int DIST_W = 17;
  localparam int FW_W   = 10;
  localparam int FH_W   = 13;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int LB_W   = 2 * PIX_W;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = FW_W'(300);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(300);
  localparam logic [FW_W-1:0] FRAME_WIDTH_MIN    = FW_W'(3);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_MIN   = FH_W'(3);
  localparam logic [FW_W-1:0] FRAME_WIDTH_MAX    = FW_W'(MAX_WIDTH);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_MAX   = FH_W'(MAX_HEIGHT);

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

endpackage
`default_nettype wire

// ----- design/mbds_in_if.sv -----
`default_nettype none
interface mbds_in_if import mbds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  feature;
  logic [DIST_W-1:0] dist_in;
  logic [PIX_W-1:0]  lower_in;
  logic [PIX_W-1:0]  upper_in;

  modport source (output valid, feature, dist_in, lower_in, upper_in, input ready);
  modport sink   (input valid, feature, dist_in, lower_in, upper_in, output ready);
endinterface
`default_nettype wire

// ----- design/mbds_out_if.sv -----
`default_nettype none
interface mbds_out_if import mbds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] dist_out;
  logic [PIX_W-1:0]  lower_out;
  logic [PIX_W-1:0]  upper_out;

  modport source (output valid, dist_out, lower_out, upper_out, input ready);
  modport sink   (input valid, dist_out, lower_out, upper_out, output ready);
endinterface
`default_nettype wire

// ----- design/mbds_ram.sv -----
`default_nettype none
module mbds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- design/minimum_barrier_distance_scan.sv -----
`default_nettype none
// Result path: input stage register, then result register, from input transfer to result valid.
// Throughput: one pixel per cycle while the output is not stalled; the left-neighbor compare-select
// is combinational and the row-above bounds come from a line buffer read at input transfer.
// Reset (rst, synchronous): scan position, left bounds and handshake state clear,
// frame size returns to 300x300. Line buffer contents are not cleared.
module minimum_barrier_distance_scan import mbds_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  mbds_in_if.sink                pix_in,
  mbds_out_if.source             pix_out,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  function automatic logic [PIX_W-1:0] barrier(input logic [PIX_W-1:0] f,
                                               input logic [PIX_W-1:0] lo,
                                               input logic [PIX_W-1:0] hi);
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] mn;
    mx = (f > hi) ? f : hi;
    mn = (f < lo) ? f : lo;
    return mx - mn;
  endfunction

  // configuration
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [FW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = {{(APB_DW-FW_W){1'b0}}, frame_width};
      REG_FRAME_HEIGHT: prdata = {{(APB_DW-FH_W){1'b0}}, frame_height};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (frame_width < FRAME_WIDTH_MIN)       w_eff = FRAME_WIDTH_MIN;
    else if (frame_width > FRAME_WIDTH_MAX)  w_eff = FRAME_WIDTH_MAX;
    else                                     w_eff = frame_width;
    if (frame_height < FRAME_HEIGHT_MIN)      h_eff = FRAME_HEIGHT_MIN;
    else if (frame_height > FRAME_HEIGHT_MAX) h_eff = FRAME_HEIGHT_MAX;
    else                                      h_eff = frame_height;
  end

  // handshake
  logic accept;
  logic fire;
  logic s1_valid;
  logic o_valid;

  assign fire         = s1_valid && (!o_valid || pix_out.ready);
  assign pix_in.ready = !s1_valid || fire;
  assign accept       = pix_in.valid && pix_in.ready;
  assign pix_out.valid = o_valid;

  // scan position
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [FW_W-1:0]  col_inc;
  logic [FH_W-1:0]  row_inc;
  logic             interior;

  assign col_inc = FW_W'(col) + FW_W'(1);
  assign row_inc = FH_W'(row) + FH_W'(1);
  assign interior = (row != '0) && (row_inc < h_eff) && (col != '0) && (col_inc < w_eff);

  always_comb begin
    col_next = col;
    row_next = row;
    if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_next = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // input stage
  logic [PIX_W-1:0]  s1_feature;
  logic [DIST_W-1:0] s1_dist;
  logic [PIX_W-1:0]  s1_lower;
  logic [PIX_W-1:0]  s1_upper;
  logic [COL_W-1:0]  s1_col;
  logic              s1_interior;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_feature  <= pix_in.feature;
      s1_dist     <= pix_in.dist_in;
      s1_lower    <= pix_in.lower_in;
      s1_upper    <= pix_in.upper_in;
      s1_col      <= col;
      s1_interior <= interior;
    end
  end

  // line buffer: bounds of the row above, read at transfer, written when the pixel retires
  logic [LB_W-1:0] lb_rd_data;
  logic [LB_W-1:0] lb_wr_data;
  logic [PIX_W-1:0] up_lower;
  logic [PIX_W-1:0] up_upper;

  mbds_ram #(
    .WIDTH (LB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (fire),
    .wr_addr (s1_col),
    .wr_data (lb_wr_data),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (lb_rd_data)
  );

  assign up_lower = lb_rd_data[LB_W-1:PIX_W];
  assign up_upper = lb_rd_data[PIX_W-1:0];

  // relaxation
  logic [PIX_W-1:0]  left_lower;
  logic [PIX_W-1:0]  left_upper;
  logic [PIX_W-1:0]  left_bar;
  logic [PIX_W-1:0]  up_bar;
  logic [DIST_W-1:0] dist_mid;
  logic [DIST_W-1:0] dist_res;
  logic [PIX_W-1:0]  lower_mid;
  logic [PIX_W-1:0]  upper_mid;
  logic [PIX_W-1:0]  lower_res;
  logic [PIX_W-1:0]  upper_res;

  assign left_bar = barrier(s1_feature, left_lower, left_upper);
  assign up_bar   = barrier(s1_feature, up_lower, up_upper);

  always_comb begin
    dist_mid  = s1_dist;
    lower_mid = s1_lower;
    upper_mid = s1_upper;
    if (s1_interior && (DIST_W'(left_bar) < s1_dist)) begin
      dist_mid  = DIST_W'(left_bar);
      lower_mid = (s1_feature < left_lower) ? s1_feature : left_lower;
      upper_mid = (s1_feature > left_upper) ? s1_feature : left_upper;
    end
    dist_res  = dist_mid;
    lower_res = lower_mid;
    upper_res = upper_mid;
    if (s1_interior && (DIST_W'(up_bar) < dist_mid)) begin
      dist_res  = DIST_W'(up_bar);
      lower_res = (s1_feature < up_lower) ? s1_feature : up_lower;
      upper_res = (s1_feature > up_upper) ? s1_feature : up_upper;
    end
  end

  assign lb_wr_data = {lower_res, upper_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      left_lower <= '0;
      left_upper <= '0;
      o_valid    <= 1'b0;
    end else begin
      if (fire) begin
        left_lower <= lower_res;
        left_upper <= upper_res;
        o_valid    <= 1'b1;
      end else if (pix_out.ready) begin
        o_valid <= 1'b0;
      end
    end
    if (fire) begin
      pix_out.dist_out  <= dist_res;
      pix_out.lower_out <= lower_res;
      pix_out.upper_out <= upper_res;
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
module tb;
  import mbds_pkg::*;

  localparam int DIST_UNSET     = 100000;
  localparam int DIST_MAX       = 2**DIST_W - 1;
  localparam int RST_CYCLES     = 7;
  localparam int STALL_CYCLES   = 150;
  localparam int DRAIN_CYCLES   = 20;
  localparam int TIMEOUT_CYCLES = 100_000;

  localparam logic [APB_AW-1:0] WIDTH_ADDR  = {REG_FRAME_WIDTH, 2'b00};
  localparam logic [APB_AW-1:0] HEIGHT_ADDR = {REG_FRAME_HEIGHT, 2'b00};

  typedef struct packed {
    logic [PIX_W-1:0]  feature;
    logic [DIST_W-1:0] distance;
    logic [PIX_W-1:0]  lower;
    logic [PIX_W-1:0]  upper;
  } pixel_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [PIX_W-1:0]  lower;
    logic [PIX_W-1:0]  upper;
  } path_t;

  typedef enum logic [1:0] {FROM_INPUT, FROM_LEFT, FROM_ABOVE} bound_source_e;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mbds_in_if  pix_in_if ();
  mbds_out_if pix_out_if ();

  minimum_barrier_distance_scan dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in_if),
    .pix_out (pix_out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // scan state mirror
  bit [PIX_W-1:0] row_lower   [MAX_WIDTH];
  bit [PIX_W-1:0] row_upper   [MAX_WIDTH];
  bit             row_written [MAX_WIDTH];
  bit [PIX_W-1:0] left_lower  = '0;
  bit [PIX_W-1:0] left_upper  = '0;
  int unsigned    scan_col    = 0;
  int unsigned    scan_row    = 0;
  bit [FW_W-1:0]  cfg_width   = FRAME_WIDTH_RESET;
  bit [FH_W-1:0]  cfg_height  = FRAME_HEIGHT_RESET;

  path_t       pending_paths [$];
  int unsigned mismatch_count  = 0;
  int unsigned pixels_sent     = 0;
  int unsigned paths_checked   = 0;
  int unsigned size_writes     = 0;
  int unsigned in_stall_cycles = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  logic        hold_off        = 1'b0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned path_barrier(int unsigned f, int unsigned lo, int unsigned hi);
    int unsigned mx, mn;
    mx = (f > hi) ? f : hi;
    mn = (f < lo) ? f : lo;
    return mx - mn;
  endfunction

  // one raster step: relax against left and upper neighbor, advance position
  function automatic path_t relax_pixel(pixel_t px);
    int unsigned   w_eff, h_eff, slot, ul, uu, left_b, up_b;
    bound_source_e winner;
    path_t         r;
    w_eff  = clamp_dim(cfg_width, MAX_WIDTH);
    h_eff  = clamp_dim(cfg_height, MAX_HEIGHT);
    slot   = (scan_col < MAX_WIDTH) ? scan_col : 0;
    r      = {px.distance, px.lower, px.upper};
    winner = FROM_INPUT;
    if (scan_row >= 1 && scan_row + 1 < h_eff && scan_col >= 1 && scan_col + 1 < w_eff) begin
      ul     = row_lower[slot];
      uu     = row_upper[slot];
      left_b = path_barrier(px.feature, left_lower, left_upper);
      up_b   = path_barrier(px.feature, ul, uu);
      if (left_b < r.distance) begin
        r.distance = DIST_W'(left_b);
        winner     = FROM_LEFT;
      end
      if (up_b < r.distance) begin
        r.distance = DIST_W'(up_b);
        winner     = FROM_ABOVE;
      end
      case (winner)
        FROM_LEFT: begin
          r.lower = (px.feature < left_lower) ? px.feature : left_lower;
          r.upper = (px.feature > left_upper) ? px.feature : left_upper;
        end
        FROM_ABOVE: begin
          r.lower = (px.feature < ul) ? px.feature : PIX_W'(ul);
          r.upper = (px.feature > uu) ? px.feature : PIX_W'(uu);
        end
        default: ;
      endcase
    end
    if (scan_col < MAX_WIDTH) begin
      row_lower[slot]   = r.lower;
      row_upper[slot]   = r.upper;
      row_written[slot] = 1'b1;
    end
    left_lower = r.lower;
    left_upper = r.upper;
    scan_col++;
    if (scan_col >= w_eff) begin
      scan_col = 0;
      scan_row++;
      if (scan_row >= h_eff) scan_row = 0;
    end
    return r;
  endfunction

  // a wider row is only allowed mid-frame once every column it reads has been written
  function automatic bit width_safe(int unsigned w);
    int unsigned w_eff;
    w_eff = clamp_dim(w, MAX_WIDTH);
    if (scan_row == 0) return 1'b1;
    for (int s = 1; s + 1 < w_eff; s++)
      if (!row_written[s]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.feature = PIX_W'($urandom);
    case ($urandom_range(19))
      0, 1, 2, 3, 4:              px.distance = DIST_W'(DIST_UNSET);
      5, 6:                       px.distance = DIST_W'($urandom_range(DIST_MAX, DIST_UNSET + 1));
      7, 8, 9, 10, 11, 12, 13:    px.distance = DIST_W'($urandom_range(255));
      default:                    px.distance = DIST_W'($urandom_range(DIST_UNSET));
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        px.lower = px.feature;
        px.upper = px.feature;
      end
      6, 7, 8: begin
        px.lower = PIX_W'($urandom_range(px.feature));
        px.upper = PIX_W'($urandom_range(255, px.feature));
      end
      default: begin
        px.lower = PIX_W'($urandom);
        px.upper = PIX_W'($urandom);
      end
    endcase
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in_if.valid    <= 1'b1;
    pix_in_if.feature  <= px.feature;
    pix_in_if.dist_in  <= px.distance;
    pix_in_if.lower_in <= px.lower;
    pix_in_if.upper_in <= px.upper;
    do @(posedge clk); while (!pix_in_if.ready);
    pending_paths.push_back(relax_pixel(px));
    pixels_sent++;
  endtask

  task automatic wait_for_idle();
    pix_in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_paths.size() != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_frame_size();
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, WIDTH_ADDR, '0, rd);
    if (rd[FW_W-1:0] !== cfg_width) begin
      $error("frame_width readback: expected %0d, actual %0d", cfg_width, rd[FW_W-1:0]);
      mismatch_count++;
    end
    apb_access(1'b0, HEIGHT_ADDR, '0, rd);
    if (rd[FH_W-1:0] !== cfg_height) begin
      $error("frame_height readback: expected %0d, actual %0d", cfg_height, rd[FH_W-1:0]);
      mismatch_count++;
    end
  endtask

  task automatic write_frame_size(input bit [FW_W-1:0] w, input bit [FH_W-1:0] h);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, WIDTH_ADDR, APB_DW'(w), rd);
    apb_access(1'b1, HEIGHT_ADDR, APB_DW'(h), rd);
    cfg_width  = w;
    cfg_height = h;
    size_writes += 2;
    check_frame_size();
  endtask

  task automatic write_random_frame_size();
    bit [FW_W-1:0] w;
    bit [FH_W-1:0] h;
    case ($urandom_range(9))
      0:       w = FW_W'($urandom_range(2));
      1:       w = FRAME_WIDTH_MAX;
      2:       w = '1;
      3:       w = FW_W'($urandom);
      default: w = FW_W'($urandom_range(12, 3));
    endcase
    case ($urandom_range(9))
      0:       h = FH_W'($urandom_range(2));
      1:       h = FRAME_HEIGHT_MAX;
      2:       h = '1;
      3:       h = FH_W'($urandom);
      default: h = FH_W'($urandom_range(10, 3));
    endcase
    if (!width_safe(w)) w = cfg_width;
    write_frame_size(w, h);
  endtask

  // shrink to 3x3 and run the scan back to the start of a frame
  task automatic restart_frame();
    write_frame_size(3, 3);
    while (scan_col != 0 || scan_row != 0) send_pixel(random_pixel());
    wait_for_idle();
  endtask

  task automatic check_path();
    path_t exp_p;
    if (pending_paths.size() == 0) begin
      $error("result with nothing expected: dist_out=%0d lower_out=%0d upper_out=%0d",
             pix_out_if.dist_out, pix_out_if.lower_out, pix_out_if.upper_out);
      mismatch_count++;
      return;
    end
    exp_p = pending_paths.pop_front();
    paths_checked++;
    if (pix_out_if.dist_out !== exp_p.distance) begin
      $error("dist_out: expected %0d, actual %0d", exp_p.distance, pix_out_if.dist_out);
      mismatch_count++;
    end
    if (pix_out_if.lower_out !== exp_p.lower) begin
      $error("lower_out: expected %0d, actual %0d", exp_p.lower, pix_out_if.lower_out);
      mismatch_count++;
    end
    if (pix_out_if.upper_out !== exp_p.upper) begin
      $error("upper_out: expected %0d, actual %0d", exp_p.upper, pix_out_if.upper_out);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pix_out_if.valid && pix_out_if.ready) check_path();
    if (!rst && pix_in_if.valid && !pix_in_if.ready) in_stall_cycles++;
    pix_out_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // 4x4 frame: border pass-through, left win, tie, up win, unset and oversized distance
  task automatic test_corner_frame();
    pixel_t frame [16];
    frame = '{
      {8'd0,   17'd0,      8'd0,   8'd0},
      {8'd255, 17'd131071, 8'd255, 8'd255},
      {8'd60,  17'd100000, 8'd40,  8'd90},
      {8'd255, 17'd0,      8'd0,   8'd255},
      {8'd50,  17'd100000, 8'd50,  8'd50},
      {8'd50,  17'd100000, 8'd10,  8'd20},
      {8'd70,  17'd20,     8'd70,  8'd70},
      {8'd128, 17'd77,     8'd200, 8'd100},
      {8'd0,   17'd100000, 8'd0,   8'd0},
      {8'd49,  17'd100000, 8'd49,  8'd49},
      {8'd255, 17'd131071, 8'd255, 8'd255},
      {8'd255, 17'd131071, 8'd255, 8'd0},
      {8'd1,   17'd1,      8'd1,   8'd1},
      {8'd128, 17'd65536,  8'd127, 8'd129},
      {8'd254, 17'd99999,  8'd0,   8'd255},
      {8'd255, 17'd100000, 8'd255, 8'd255}
    };
    send_idle_pct = 35;
    recv_idle_pct <= 79;
    check_frame_size();
    write_frame_size(4, 4);
    foreach (frame[i]) send_pixel(frame[i]);
    wait_for_idle();
  endtask

  // sizes below the minimum count as 3
  task automatic test_size_clamping();
    write_frame_size(2, 0);
    repeat (9) send_pixel(random_pixel());
    wait_for_idle();
  endtask

  // width clamps at the maximum: one full row, then the start of the next
  task automatic test_widest_frame();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    restart_frame();
    write_frame_size('1, 3);
    repeat (MAX_WIDTH + 12) send_pixel(random_pixel());
    wait_for_idle();
  endtask

  // height clamps at the maximum, width below the minimum runs three-pixel rows
  task automatic test_tallest_frame();
    write_frame_size(0, '1);
    repeat (12) send_pixel(random_pixel());
    wait_for_idle();
  endtask

  task automatic test_output_stall();
    write_frame_size(9, 5);
    fork
      begin
        hold_off <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (40) send_pixel(random_pixel());
    wait_for_idle();
  endtask

  task automatic test_random_scan(input int unsigned send_pct, input int unsigned recv_pct,
                                  input int unsigned count);
    int unsigned sent, chunk;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    sent = 0;
    while (sent < count) begin
      chunk = $urandom_range(30, 10);
      repeat (chunk) send_pixel(random_pixel());
      sent += chunk;
      wait_for_idle();
      write_random_frame_size();
    end
  endtask

  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    pix_in_if.valid    = 1'b0;
    pix_in_if.feature  = '0;
    pix_in_if.dist_in  = '0;
    pix_in_if.lower_in = '0;
    pix_in_if.upper_in = '0;
    pix_out_if.ready   = 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_frame();
    test_size_clamping();
    test_random_scan(35, 79, 70);
    test_random_scan(79, 35, 70);
    test_widest_frame();
    test_tallest_frame();
    test_output_stall();
    test_random_scan(0, 0, 70);

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Scanned %0d pixels, checked %0d results, %0d frame size register writes",
             pixels_sent, paths_checked, size_writes);
    $display("Input held off by the block for %0d cycles", in_stall_cycles);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Timeout waiting for the scan to finish");
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- minimum_barrier_distance_scan.f -----
design/mbds_pkg.sv
design/mbds_in_if.sv
design/mbds_out_if.sv
design/mbds_ram.sv
design/minimum_barrier_distance_scan.sv
verif/tb.sv
